// ===== rtl/ottc_pkg.sv =====
// ----------------------------------------------------------------------------
// ottc_pkg
// Shared types and constants of the three-class Otsu threshold block.
// ----------------------------------------------------------------------------
package ottc_pkg;

    // Input commands.
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CALC  = 2'd1;
    localparam logic [1:0] CMD_CLASS = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Result kinds.
    localparam logic KIND_CUTS  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // Output grey levels of the classifier.
    localparam logic [7:0] GREY_ABOVE = 8'd255;
    localparam logic [7:0] GREY_BELOW = 8'd127;
    localparam logic [7:0] GREY_MID   = 8'd0;

    // Histogram control from the top level.
    typedef struct packed {
        logic add;
        logic rd;
        logic clear;
    } t_hist_ctl;

    // Threshold search status toward the top level.
    typedef struct packed {
        logic       done;
        logic [7:0] lo;
        logic [7:0] hi;
    } t_search_out;

endpackage

// ===== rtl/otsu_two_threshold_classifier.sv =====
// ----------------------------------------------------------------------------
// otsu_two_threshold_classifier
// Three-class Otsu histogram, threshold pair search and pixel classifier.
// ----------------------------------------------------------------------------
// Add pixel: one transfer per cycle when idle and output free; no result.
// Classify: result registered in the cycle after the transfer, one per cycle
// while the output drains. Compute: a prefix sweep, then one square-over-count
// pass per non-empty low class and two per pair with non-empty middle and
// upper classes. Reset (synchronous, active low) empties the histogram through
// its valid bits at once and zeroes both thresholds; no clearing pass needed.
module otsu_two_threshold_classifier #(
    parameter int BIN_COUNT  = 256,
    parameter int COUNT_BITS = 22
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_pixel,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_result_kind,
    output logic [7:0] o_low_threshold,
    output logic [7:0] o_high_threshold,
    output logic [7:0] o_class_value
);
    import ottc_pkg::*;

    localparam int IB = $clog2(BIN_COUNT);
    localparam logic [7:0] LAST_BIN = 8'(BIN_COUNT - 1);

    // Control: idle takes transfers; search waits for the sequencer; report
    // waits for a free output register.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_REPORT = 3'b100
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [7:0]  r_lo_cut;
    logic [7:0]  r_hi_cut;
    logic        r_out_valid;
    logic        r_kind;
    logic [7:0]  r_lo_out;
    logic [7:0]  r_hi_out;
    logic [7:0]  r_class;

    logic                  in_acc;
    logic                  slot_free;
    logic                  load_pix;
    logic                  load_rep;
    logic [IB-1:0]         add_idx;
    logic [7:0]            grey;
    t_hist_ctl             hist_ctl;
    t_search_out           srch;
    logic                  srch_rd;
    logic [IB-1:0]         srch_idx;
    logic [COUNT_BITS-1:0] hist_data;

    // The output register frees itself when its result is taken this cycle.
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !slot_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign load_pix   = in_acc && (i_cmd == CMD_CLASS);
    assign load_rep   = (r_state == ST_REPORT) && slot_free;

    // Pixels beyond the last bin land in the last bin.
    assign add_idx = (i_pixel > LAST_BIN) ? IB'(BIN_COUNT - 1) : i_pixel[IB-1:0];

    assign grey = (i_pixel > r_hi_cut) ? GREY_ABOVE :
                  (i_pixel < r_lo_cut) ? GREY_BELOW : GREY_MID;

    // The histogram is emptied in the cycle the search reports its pair.
    assign hist_ctl.add   = in_acc && (i_cmd == CMD_ADD);
    assign hist_ctl.rd    = srch_rd;
    assign hist_ctl.clear = srch.done;

    ottc_hist #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (hist_ctl),
        .i_add_idx (add_idx),
        .i_rd_idx  (srch_idx),
        .o_rd_data (hist_data)
    );

    ottc_search #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc && (i_cmd == CMD_CALC)),
        .o_hist_rd   (srch_rd),
        .o_hist_idx  (srch_idx),
        .i_hist_data (hist_data),
        .o_status    (srch)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_acc && (i_cmd == CMD_CALC)) n_state = ST_SEARCH;
            ST_SEARCH: if (srch.done) n_state = ST_REPORT;
            ST_REPORT: if (slot_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_lo_cut    <= '0;
            r_hi_cut    <= '0;
        end else begin
            r_state <= n_state;
            if (srch.done) begin
                r_lo_cut <= srch.lo;
                r_hi_cut <= srch.hi;
            end
            if (slot_free) begin
                r_out_valid <= load_pix || load_rep;
            end
        end
    end

    // Result payload; a classified pixel carries the thresholds in force.
    always_ff @(posedge i_clk) begin
        if (load_pix) begin
            r_kind   <= KIND_PIXEL;
            r_lo_out <= r_lo_cut;
            r_hi_out <= r_hi_cut;
            r_class  <= grey;
        end else if (load_rep) begin
            r_kind   <= KIND_CUTS;
            r_lo_out <= r_lo_cut;
            r_hi_out <= r_hi_cut;
            r_class  <= GREY_MID;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_low_threshold  = r_lo_out;
    assign o_high_threshold = r_hi_out;
    assign o_class_value    = r_class;

`ifndef ASSERT_OFF
    a_done_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch.done |-> (r_state == ST_SEARCH))
        else $error("search finished outside of a search");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> (r_state == ST_IDLE))
        else $error("transfer accepted while busy");

    a_report_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_rep |=> (r_out_valid && (r_kind == KIND_CUTS) && (r_state == ST_IDLE)))
        else $error("threshold report not loaded");
`endif

endmodule

// ===== rtl/ottc_hist.sv =====
// ----------------------------------------------------------------------------
// ottc_hist
// Histogram memory with valid bits, saturating read-modify-write update.
// ----------------------------------------------------------------------------
module ottc_hist #(
    parameter int BIN_COUNT  = 256,
    parameter int COUNT_BITS = 22
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ottc_pkg::t_hist_ctl          i_ctl,
    input  logic [$clog2(BIN_COUNT)-1:0] i_add_idx,
    input  logic [$clog2(BIN_COUNT)-1:0] i_rd_idx,
    output logic [COUNT_BITS-1:0]        o_rd_data
);
    import ottc_pkg::*;

    localparam int IB = $clog2(BIN_COUNT);

    logic [COUNT_BITS-1:0] r_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]  r_vld;
    logic [COUNT_BITS-1:0] r_rd;
    logic                  r_rd_vld;
    logic                  r_s1_add;
    logic [IB-1:0]         r_s1_idx;
    logic                  r_fw_vld;
    logic [IB-1:0]         r_fw_idx;
    logic [COUNT_BITS-1:0] r_fw_data;

    logic [IB-1:0]         rd_addr;
    logic                  rd_en;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;

    assign rd_addr   = i_ctl.add ? i_add_idx : i_rd_idx;
    assign rd_en     = i_ctl.add | i_ctl.rd;
    assign o_rd_data = r_rd_vld ? r_rd : '0;

    // The entry written at the edge of our own read is forwarded.
    assign cur = (r_fw_vld && (r_fw_idx == r_s1_idx)) ? r_fw_data : o_rd_data;
    assign inc = (&cur) ? cur : cur + COUNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd     <= r_mem[rd_addr];
            r_rd_vld <= r_vld[rd_addr];
        end
        if (r_s1_add) begin
            r_mem[r_s1_idx] <= inc;
        end
        r_s1_idx  <= rd_addr;
        r_fw_idx  <= r_s1_idx;
        r_fw_data <= inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_s1_add <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            r_s1_add <= i_ctl.add;
            r_fw_vld <= r_s1_add & ~i_ctl.clear;
            if (i_ctl.clear) begin
                r_vld <= '0;
            end else if (r_s1_add) begin
                r_vld[r_s1_idx] <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ottc_sqdiv.sv =====
// ----------------------------------------------------------------------------
// ottc_sqdiv
// Sequential unit for floor(S*S/W), using S = q*W + r.
// ----------------------------------------------------------------------------
module ottc_sqdiv #(
    parameter int BIN_COUNT  = 256,
    parameter int COUNT_BITS = 22
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_start,
    input  logic [COUNT_BITS+2*$clog2(BIN_COUNT)-1:0]         i_s,
    input  logic [COUNT_BITS+$clog2(BIN_COUNT)-1:0]           i_w,
    output logic                                              o_done,
    output logic [COUNT_BITS+3*$clog2(BIN_COUNT)-1:0]         o_res
);
    import ottc_pkg::*;

    localparam int QB   = $clog2(BIN_COUNT);
    localparam int WB   = COUNT_BITS + QB;
    localparam int SB   = COUNT_BITS + 2 * QB;
    localparam int RB   = SB + QB;
    localparam int CNTB = $clog2(SB);

    typedef enum logic [6:0] {
        DV_IDLE = 7'b0000001,
        DV_QR   = 7'b0000010,
        DV_SQA  = 7'b0000100,
        DV_SQB  = 7'b0001000,
        DV_MUL  = 7'b0010000,
        DV_SUM  = 7'b0100000,
        DV_OUT  = 7'b1000000
    } t_dv_state;

    t_dv_state       r_state;
    t_dv_state       n_state;
    logic [SB-1:0]   r_s;
    logic [SB-1:0]   r_dvd;
    logic [WB-1:0]   r_w;
    logic [WB-1:0]   r_rem;
    logic [QB-1:0]   r_quo;
    logic [WB-1:0]   r_rb;
    logic [WB-1:0]   r_sqr;
    logic [WB-1:0]   r_sqq;
    logic [CNTB-1:0] r_cnt;
    logic [RB-1:0]   r_p1;
    logic [WB+QB-1:0] r_p2;
    logic [RB-1:0]   r_res;

    logic [WB:0] qr_t;
    logic        qr_ge;
    logic [WB:0] sa_t;
    logic        sa_ge;
    logic [WB:0] sb_t;
    logic        sb_ge;

    assign qr_t  = {r_rem, r_dvd[SB-1]};
    assign qr_ge = qr_t >= {1'b0, r_w};
    assign sa_t  = {r_sqr, 1'b0};
    assign sa_ge = sa_t >= {1'b0, r_w};
    assign sb_t  = {1'b0, r_sqr} + {1'b0, r_rem};
    assign sb_ge = sb_t >= {1'b0, r_w};

    assign o_done = (r_state == DV_OUT);
    assign o_res  = r_res;

    // A new operand pair may also start in the cycle the previous result is
    // presented, so two passes can run back to back.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE: if (i_start) n_state = DV_QR;
            DV_QR:   if (r_cnt == '0) n_state = DV_SQA;
            DV_SQA:  n_state = DV_SQB;
            DV_SQB:  if (r_cnt == '0) n_state = DV_MUL; else n_state = DV_SQA;
            DV_MUL:  n_state = DV_SUM;
            DV_SUM:  n_state = DV_OUT;
            DV_OUT:  n_state = i_start ? DV_QR : DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE, DV_OUT: begin
                r_s   <= i_s;
                r_dvd <= i_s;
                r_w   <= i_w;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= CNTB'(SB - 1);
            end
            DV_QR: begin
                r_rem <= qr_ge ? WB'(qr_t - {1'b0, r_w}) : qr_t[WB-1:0];
                r_quo <= {r_quo[QB-2:0], qr_ge};
                r_dvd <= {r_dvd[SB-2:0], 1'b0};
                r_cnt <= r_cnt - CNTB'(1);
                if (r_cnt == '0) begin
                    r_rb  <= qr_ge ? WB'(qr_t - {1'b0, r_w}) : qr_t[WB-1:0];
                    r_sqr <= '0;
                    r_sqq <= '0;
                    r_cnt <= CNTB'(WB - 1);
                end
            end
            DV_SQA: begin
                r_sqr <= sa_ge ? WB'(sa_t - {1'b0, r_w}) : sa_t[WB-1:0];
                r_sqq <= {r_sqq[WB-2:0], sa_ge};
            end
            DV_SQB: begin
                if (r_rb[WB-1]) begin
                    r_sqr <= sb_ge ? WB'(sb_t - {1'b0, r_w}) : sb_t[WB-1:0];
                    r_sqq <= r_sqq + WB'(sb_ge);
                end
                r_rb  <= {r_rb[WB-2:0], 1'b0};
                r_cnt <= r_cnt - CNTB'(1);
            end
            DV_MUL: begin
                r_p1 <= RB'(r_quo) * RB'(r_s);
                r_p2 <= (WB + QB)'(r_quo) * (WB + QB)'(r_rem);
            end
            DV_SUM: begin
                r_res <= r_p1 + RB'(r_p2) + RB'(r_sqq);
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/ottc_search.sv =====
// ----------------------------------------------------------------------------
// ottc_search
// Prefix-sum memory and the sequencer of the threshold pair search.
// ----------------------------------------------------------------------------
module ottc_search #(
    parameter int BIN_COUNT  = 256,
    parameter int COUNT_BITS = 22
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_hist_rd,
    output logic [$clog2(BIN_COUNT)-1:0] o_hist_idx,
    input  logic [COUNT_BITS-1:0]        i_hist_data,
    output ottc_pkg::t_search_out        o_status
);
    import ottc_pkg::*;

    localparam int IB  = $clog2(BIN_COUNT);
    localparam int WB  = COUNT_BITS + IB;
    localparam int SB  = COUNT_BITS + 2 * IB;
    localparam int RB  = SB + IB;
    localparam int CRB = RB + 2;

    typedef enum logic [11:0] {
        SS_IDLE   = 12'b000000000001,
        SS_PRE_RD = 12'b000000000010,
        SS_PRE_WR = 12'b000000000100,
        SS_LO_RD  = 12'b000000001000,
        SS_LO_CHK = 12'b000000010000,
        SS_LO_DIV = 12'b000000100000,
        SS_HI_RD  = 12'b000001000000,
        SS_HI_CHK = 12'b000010000000,
        SS_HI_DV2 = 12'b000100000000,
        SS_HI_DV3 = 12'b001000000000,
        SS_CMP    = 12'b010000000000,
        SS_DONE   = 12'b100000000000
    } t_ss_state;

    t_ss_state        r_state;
    t_ss_state        n_state;
    logic [WB+SB-1:0] r_pmem [BIN_COUNT];
    logic [WB+SB-1:0] r_prd;
    logic [IB-1:0]    r_k;
    logic [IB-1:0]    r_lo;
    logic [IB-1:0]    r_hi;
    logic [WB-1:0]    r_pw;
    logic [SB-1:0]    r_ps;
    logic [WB-1:0]    r_w1;
    logic [SB-1:0]    r_s1;
    logic [WB-1:0]    r_w3;
    logic [SB-1:0]    r_s3;
    logic [RB-1:0]    r_t1;
    logic [RB-1:0]    r_t2;
    logic [CRB-1:0]   r_crit;
    logic [CRB-1:0]   r_best;
    logic             r_found;
    logic [IB-1:0]    r_best_lo;
    logic [IB-1:0]    r_best_hi;

    logic [WB-1:0] pre_w;
    logic [SB-1:0] pre_s;
    logic [WB-1:0] p_w;
    logic [SB-1:0] p_s;
    logic [WB-1:0] w2;
    logic [SB-1:0] s2;
    logic [WB-1:0] w3;
    logic [SB-1:0] s3;
    logic          skip;
    logic          lo_last;
    logic          hi_last;
    logic          better;
    logic          div_start;
    logic [SB-1:0] div_s;
    logic [WB-1:0] div_w;
    logic          div_done;
    logic [RB-1:0] div_res;
    logic          pm_rd;
    logic [IB-1:0] pm_addr;

    assign pre_w   = r_pw + WB'(i_hist_data);
    assign pre_s   = r_ps + SB'(i_hist_data) * SB'(r_k);
    assign p_w     = r_prd[WB+SB-1:SB];
    assign p_s     = r_prd[SB-1:0];
    assign w2      = p_w - r_w1;
    assign s2      = p_s - r_s1;
    assign w3      = r_pw - p_w;
    assign s3      = r_ps - p_s;
    assign skip    = (w2 == '0) || (w3 == '0);
    assign lo_last = (r_lo == IB'(BIN_COUNT - 2));
    assign hi_last = (r_hi == IB'(BIN_COUNT - 1));
    assign better  = !r_found || (r_crit > r_best);

    assign pm_rd   = (r_state == SS_LO_RD) || (r_state == SS_HI_RD);
    assign pm_addr = (r_state == SS_LO_RD) ? r_lo : r_hi;

    assign div_start = ((r_state == SS_LO_CHK) && (p_w != '0))
                     || ((r_state == SS_HI_CHK) && !skip)
                     || ((r_state == SS_HI_DV2) && div_done);
    assign div_s = (r_state == SS_LO_CHK) ? p_s : (r_state == SS_HI_CHK) ? s2 : r_s3;
    assign div_w = (r_state == SS_LO_CHK) ? p_w : (r_state == SS_HI_CHK) ? w2 : r_w3;

    assign o_hist_rd       = (r_state == SS_PRE_RD);
    assign o_hist_idx      = r_k;
    assign o_status.done   = (r_state == SS_DONE);
    assign o_status.lo     = 8'(r_best_lo);
    assign o_status.hi     = 8'(r_best_hi);

    ottc_sqdiv #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_s     (div_s),
        .i_w     (div_w),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SS_IDLE:   if (i_start) n_state = SS_PRE_RD;
            SS_PRE_RD: n_state = SS_PRE_WR;
            SS_PRE_WR: n_state = (r_k == IB'(BIN_COUNT - 1)) ? SS_LO_RD : SS_PRE_RD;
            SS_LO_RD:  n_state = SS_LO_CHK;
            SS_LO_CHK: begin
                if (p_w != '0) n_state = SS_LO_DIV;
                else n_state = lo_last ? SS_DONE : SS_LO_RD;
            end
            SS_LO_DIV: if (div_done) n_state = SS_HI_RD;
            SS_HI_RD:  n_state = SS_HI_CHK;
            SS_HI_CHK, SS_CMP: begin
                if ((r_state == SS_HI_CHK) && !skip) n_state = SS_HI_DV2;
                else if (!hi_last) n_state = SS_HI_RD;
                else n_state = lo_last ? SS_DONE : SS_LO_RD;
            end
            SS_HI_DV2: if (div_done) n_state = SS_HI_DV3;
            SS_HI_DV3: if (div_done) n_state = SS_CMP;
            SS_DONE:   n_state = SS_IDLE;
            default:   n_state = SS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SS_PRE_WR) begin
            r_pmem[r_k] <= {pre_w, pre_s};
        end
        if (pm_rd) begin
            r_prd <= r_pmem[pm_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SS_IDLE: begin
                if (i_start) begin
                    r_k       <= '0;
                    r_pw      <= '0;
                    r_ps      <= '0;
                    r_found   <= 1'b0;
                    r_best_lo <= '0;
                    r_best_hi <= '0;
                end
            end
            SS_PRE_WR: begin
                r_pw <= pre_w;
                r_ps <= pre_s;
                r_k  <= r_k + IB'(1);
                r_lo <= '0;
            end
            SS_LO_CHK: begin
                r_w1 <= p_w;
                r_s1 <= p_s;
                if (p_w == '0) r_lo <= r_lo + IB'(1);
            end
            SS_LO_DIV: begin
                if (div_done) begin
                    r_t1 <= div_res;
                    r_hi <= r_lo + IB'(1);
                end
            end
            SS_HI_CHK, SS_CMP: begin
                if (r_state == SS_HI_CHK) begin
                    r_w3 <= w3;
                    r_s3 <= s3;
                end else if (better) begin
                    r_found   <= 1'b1;
                    r_best    <= r_crit;
                    r_best_lo <= r_lo;
                    r_best_hi <= r_hi;
                end
                if ((r_state == SS_CMP) || skip) begin
                    if (hi_last) r_lo <= r_lo + IB'(1);
                    else r_hi <= r_hi + IB'(1);
                end
            end
            SS_HI_DV2: begin
                if (div_done) r_t2 <= div_res;
            end
            SS_HI_DV3: begin
                if (div_done) r_crit <= CRB'(r_t1) + CRB'(r_t2) + CRB'(div_res);
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the three-class Otsu classifier against a histogram and threshold
// search model kept in the testbench, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    import ottc_pkg::*;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] pixel;
    } t_pix_item;

    typedef struct {
        logic       kind;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] grey;
    } t_grey_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_cmd;
    logic [7:0] i_pixel;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_result_kind;
    logic [7:0] o_low_threshold;
    logic [7:0] o_high_threshold;
    logic [7:0] o_class_value;

    otsu_two_threshold_classifier u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_pixel          (i_pixel),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_low_threshold  (o_low_threshold),
        .o_high_threshold (o_high_threshold),
        .o_class_value    (o_class_value)
    );

    // Pending input items and results that are still owed by the block.
    t_pix_item    pixel_feed[$];
    t_grey_result grey_owed[$];

    // Model state: the histogram and the current pair of cuts.
    longint unsigned hist_bins[256];
    logic [7:0]      cut_lo;
    logic [7:0]      cut_hi;

    int  mismatch_count;
    int  result_count;
    bit  in_took;
    bit  out_took;
    int  send_gap;
    int  recv_hold;
    bit  long_hold_done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Exhaustive pair search over the histogram; the first strict maximum wins.
    task automatic search_cuts();
        longint unsigned pw[257];
        longint unsigned ps[257];
        longint unsigned best;
        longint unsigned crit;
        longint unsigned w1, s1, w2, s2, w3, s3;
        bit found;
        int best_lo, best_hi;
        best = 0;
        found = 0;
        best_lo = 0;
        best_hi = 0;
        pw[0] = 0;
        ps[0] = 0;
        for (int k = 0; k < 256; k++) begin
            pw[k + 1] = pw[k] + hist_bins[k];
            ps[k + 1] = ps[k] + hist_bins[k] * k;
        end
        for (int lo = 0; lo < 255; lo++) begin
            w1 = pw[lo + 1];
            s1 = ps[lo + 1];
            if (w1 == 0) continue;
            for (int hi = lo + 1; hi < 256; hi++) begin
                w2 = pw[hi + 1] - w1;
                s2 = ps[hi + 1] - s1;
                w3 = pw[256] - pw[hi + 1];
                s3 = ps[256] - ps[hi + 1];
                if (w2 == 0 || w3 == 0) continue;
                // Sums stay far below 2^32 here, so the squares fit in 64 bits.
                crit = (s1 * s1) / w1 + (s2 * s2) / w2 + (s3 * s3) / w3;
                if (!found || crit > best) begin
                    found = 1;
                    best = crit;
                    best_lo = lo;
                    best_hi = hi;
                end
            end
        end
        cut_lo = best_lo[7:0];
        cut_hi = best_hi[7:0];
    endtask

    // Applies one accepted item to the model and queues the result it owes.
    task automatic predict_grey(input logic [1:0] cmd, input logic [7:0] pix);
        t_grey_result r;
        case (cmd)
            CMD_ADD: begin
                if (hist_bins[pix] < 64'd4194303) hist_bins[pix]++;
            end
            CMD_CALC: begin
                search_cuts();
                foreach (hist_bins[k]) hist_bins[k] = 0;
                r.kind = KIND_CUTS;
                r.lo = cut_lo;
                r.hi = cut_hi;
                r.grey = GREY_MID;
                grey_owed.push_back(r);
            end
            CMD_CLASS: begin
                r.kind = KIND_PIXEL;
                r.lo = cut_lo;
                r.hi = cut_hi;
                if (pix > cut_hi) r.grey = GREY_ABOVE;
                else if (pix < cut_lo) r.grey = GREY_BELOW;
                else r.grey = GREY_MID;
                grey_owed.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] pix);
        t_pix_item it;
        it.cmd = cmd;
        it.pixel = pix;
        pixel_feed.push_back(it);
    endtask

    // One frame of pixels inside [base, base+span] with occasional unused commands, then the search.
    task automatic push_frame(input int base, input int span, input int npix);
        int p;
        for (int n = 0; n < npix; n++) begin
            p = base + $urandom_range(0, span);
            if (p > 255) p = 255;
            push_item(CMD_ADD, p[7:0]);
            if ($urandom_range(0, 19) == 0) push_item(CMD_SPARE, 8'($urandom_range(0, 255)));
        end
        push_item(CMD_CALC, 8'($urandom_range(0, 255)));
    endtask

    // Transfers are recorded at the rising edge, where the inputs are stable.
    always @(posedge i_clk) begin
        in_took <= i_rst_n && i_in_valid && !o_in_stall;
        out_took <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_grey(i_cmd, i_pixel);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count <= result_count + 1;
            if (grey_owed.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result kind=%0d lo=%0d hi=%0d grey=%0d",
                             o_result_kind, o_low_threshold, o_high_threshold,
                             o_class_value);
            end else begin
                t_grey_result e;
                e = grey_owed.pop_front();
                if (o_result_kind !== e.kind || o_low_threshold !== e.lo ||
                    o_high_threshold !== e.hi || o_class_value !== e.grey) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected kind=%0d lo=%0d hi=%0d grey=%0d, got kind=%0d lo=%0d hi=%0d grey=%0d",
                                 e.kind, e.lo, e.hi, e.grey, o_result_kind,
                                 o_low_threshold, o_high_threshold, o_class_value);
                end
            end
        end
    end

    // Driver: a held item stays put until its transfer, then a random gap.
    always @(negedge i_clk) begin
        t_pix_item it;
        bit        nxt_valid;
        nxt_valid = i_in_valid;
        if (i_rst_n) begin
            if (!i_in_valid || in_took) begin
                nxt_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pixel_feed.size() > 0) begin
                    it = pixel_feed.pop_front();
                    i_cmd <= it.cmd;
                    i_pixel <= it.pixel;
                    nxt_valid = 1'b1;
                    send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // Receiver: a short random stall per result, and one long hold-off
    // while the sender keeps offering, so the block backs up.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_took) begin
                if (result_count == 40 && !long_hold_done) begin
                    recv_hold = 300;
                    long_hold_done = 1'b1;
                end else begin
                    recv_hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int base;
        int span;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = CMD_ADD;
        i_pixel = 8'd0;
        i_out_stall = 1'b0;
        mismatch_count = 0;
        result_count = 0;
        send_gap = 0;
        recv_hold = 0;
        long_hold_done = 1'b0;
        cut_lo = 8'd0;
        cut_hi = 8'd0;
        foreach (hist_bins[k]) hist_bins[k] = 0;

        // Directed: extremes with zero cuts, search on an empty histogram,
        // a single-bin frame with no valid pair, both ends of the grey scale,
        // and the unused command.
        push_item(CMD_CLASS, 8'd0);
        push_item(CMD_CLASS, 8'd255);
        push_item(CMD_CALC, 8'd0);
        push_item(CMD_ADD, 8'd7);
        push_item(CMD_ADD, 8'd7);
        push_item(CMD_CALC, 8'd255);
        push_item(CMD_SPARE, 8'd170);
        push_item(CMD_ADD, 8'd0);
        push_item(CMD_ADD, 8'd1);
        push_item(CMD_ADD, 8'd3);
        push_item(CMD_ADD, 8'd5);
        push_item(CMD_CALC, 8'd85);
        push_item(CMD_CLASS, 8'd0);
        push_item(CMD_CLASS, 8'd3);
        push_item(CMD_CLASS, 8'd255);
        push_item(CMD_ADD, 8'd250);
        push_item(CMD_ADD, 8'd252);
        push_item(CMD_ADD, 8'd255);
        push_item(CMD_ADD, 8'd255);
        push_item(CMD_CALC, 8'd0);
        push_item(CMD_CLASS, 8'd251);
        push_item(CMD_CLASS, 8'd255);
        push_item(CMD_CLASS, 8'd0);

        // Random frames. Narrow grey ranges keep the pair search short; a frame of
        // span 40, drawn at random, exercises a longer scan.
        while (pixel_feed.size() < 800) begin
            span = ($urandom_range(0, 29) == 0) ? 40 : $urandom_range(0, 10);
            base = $urandom_range(0, 255 - span);
            push_frame(base, span, $urandom_range(1, 30));
            for (int n = $urandom_range(0, 12); n > 0; n--) begin
                if ($urandom_range(0, 1)) push_item(CMD_CLASS, 8'($urandom_range(0, 255)));
                else push_item(CMD_CLASS, 8'(base + $urandom_range(0, span)));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pixel_feed.size() == 0 && !i_in_valid);
        wait (grey_owed.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && grey_owed.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #1_000_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
